>>> src/smpq_pkg.sv
// Package for the stable minimum priority queue.
// Holds payload types, status and opcode codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package smpq_pkg;

  typedef logic [15:0]        value_t;
  typedef logic signed [15:0] prio_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_INSERTED = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_REMOVED  = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_SHIFT,
    ST_DONE
  } state_e;

  typedef struct packed {
    prio_t  prio;
    value_t value;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic setup;
    logic shift;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> src/smpq_in_if.sv
// Input channel of the priority queue: valid, ready and the request beat.
// Depends on smpq_pkg.
interface smpq_in_if;
  logic            valid;
  logic            ready;
  logic            op;
  smpq_pkg::value_t value;
  smpq_pkg::prio_t  priority_req;

  modport source (output valid, output op, output value, output priority_req, input ready);
  modport sink   (input valid, input op, input value, input priority_req, output ready);
endinterface

>>> src/smpq_out_if.sv
// Output channel of the priority queue: valid, ready and the result beat.
// Depends on smpq_pkg.
interface smpq_out_if;
  logic             valid;
  logic             ready;
  smpq_pkg::value_t value_out;
  logic [1:0]       status;
  logic [5:0]       count;

  modport source (output valid, output value_out, output status, output count, input ready);
  modport sink   (input valid, input value_out, input status, input count, output ready);
endinterface

>>> src/smpq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module smpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/smpq_ctrl.sv
// Controller state machine of the priority queue.
// Sequences accept, scan, shift and result load. Depends on smpq_pkg.
module smpq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smpq_pkg::dp_sts_t sts_i,
  output smpq_pkg::dp_cmd_t cmd_o
);
  import smpq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/smpq_datapath.sv
// Datapath of the priority queue: entry RAM, count, scan and shift pointers,
// best-entry registers and the output register. Depends on smpq_pkg, smpq_ram.
module smpq_datapath #(
  parameter int CAPACITY = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_op_i,
  input  smpq_pkg::value_t  in_value_i,
  input  smpq_pkg::prio_t   in_prio_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output smpq_pkg::value_t  out_value_o,
  output logic [1:0]        out_status_o,
  output logic [5:0]        out_count_o,
  input  smpq_pkg::dp_cmd_t cmd_i,
  output smpq_pkg::dp_sts_t sts_o
);
  import smpq_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic             issuing_q, issuing_d;
  logic             rd_vld_q, rd_vld_d;
  logic [AW-1:0]    rd_idx_q;
  logic [AW-1:0]    last_idx;
  logic             full;
  logic             is_insert;

  logic [AW-1:0]    best_idx_q;
  prio_t            best_prio_q;
  value_t           best_val_q;
  value_t           res_val_q;
  status_e          status_q;
  logic             out_valid_q;
  value_t           out_value_q;
  status_e          out_status_q;
  logic [5:0]       out_count_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;
  logic             better;

  assign last_idx  = AW'(count_q - CNT_W'(1));
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign is_insert = (in_op_i == OP_INSERT);
  assign better    = (rd_idx_q == '0) || (ram_rdata.prio < best_prio_q);

  smpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_idx_q - AW'(1);
    ram_wdata = ram_rdata;
    if (cmd_i.accept && is_insert && !full) begin
      ram_we          = 1'b1;
      ram_waddr       = count_q[AW-1:0];
      ram_wdata.prio  = in_prio_i;
      ram_wdata.value = in_value_i;
    end else if (cmd_i.shift && rd_vld_q) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    count_d   = count_q;
    ptr_d     = ptr_q;
    issuing_d = issuing_q;
    rd_vld_d  = 1'b0;
    if (cmd_i.accept) begin
      ptr_d     = '0;
      issuing_d = sts_o.need_scan;
      if (is_insert && !full) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (cmd_i.setup) begin
      ptr_d     = best_idx_q + AW'(1);
      issuing_d = (best_idx_q != last_idx);
    end else if (cmd_i.scan || cmd_i.shift) begin
      rd_vld_d = issuing_q;
      if (issuing_q) begin
        if (ptr_q == last_idx) begin
          issuing_d = 1'b0;
        end else begin
          ptr_d = ptr_q + AW'(1);
        end
      end
      if (cmd_i.shift && sts_o.shift_done) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      issuing_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      ptr_q     <= ptr_d;
      issuing_q <= issuing_d;
      rd_vld_q  <= rd_vld_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= ptr_q;
    if (cmd_i.accept) begin
      res_val_q <= '0;
      if (is_insert) begin
        status_q <= full ? STATUS_FULL : STATUS_INSERTED;
      end else begin
        status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_REMOVED;
      end
    end
    if (cmd_i.scan && rd_vld_q && better) begin
      best_idx_q  <= rd_idx_q;
      best_prio_q <= ram_rdata.prio;
      best_val_q  <= ram_rdata.value;
    end
    if (cmd_i.setup) begin
      res_val_q <= best_val_q;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_val_q;
      out_status_q <= status_q;
      out_count_q  <= 6'(count_q);
    end
  end

  assign sts_o.need_scan  = !is_insert && (count_q != '0);
  assign sts_o.scan_done  = rd_vld_q && (rd_idx_q == last_idx);
  assign sts_o.shift_done = !issuing_q && !rd_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;

endmodule

>>> src/stable_min_priority_queue_top.sv
// Stable minimum priority queue, top level. An insert goes from accept
// straight to the result load; a remove over N held entries scans all N and
// then shifts the entries behind the smallest one down, both through the one
// read port of the entry RAM. The next item is accepted only after the result load.
// One item is in work at a time; the output register lets the next item in
// while a result waits. Reset empties the queue; entry RAM is not cleared.
// Depends on smpq_pkg, smpq_in_if, smpq_out_if, smpq_ctrl, smpq_datapath.
module stable_min_priority_queue_top #(
  parameter int CAPACITY = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smpq_in_if.sink    in_i,
  smpq_out_if.source out_o
);
  import smpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  smpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (in_i.op),
    .in_value_i   (in_i.value),
    .in_prio_i    (in_i.priority_req),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_value_o  (out_o.value_out),
    .out_status_o (out_o.status),
    .out_count_o  (out_o.count),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

>>> sim/smpq_queue_checker.sv
// Watches both channels of the stable minimum priority queue, keeps its own copy of the
// held entries to work out each result, and compares the result beats in order.
// Depends on smpq_pkg, smpq_in_if and smpq_out_if.
`timescale 1ns / 100ps

module smpq_queue_checker #(
  parameter int CAPACITY = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  smpq_in_if   req_i,
  smpq_out_if  rsp_i,
  output int   errors_o,
  output int   pending_o
);
  import smpq_pkg::*;

  typedef struct packed {
    value_t     value_out;
    status_e    status;
    logic [5:0] count;
  } result_t;

  value_t  held_value[$];
  prio_t   held_prio[$];
  result_t expected_results[$];
  result_t oldest;

  function automatic result_t apply_request(op_e op, value_t value, prio_t prio);
    result_t r;
    int best;
    r.value_out = '0;
    if (op == OP_INSERT) begin
      if (held_value.size() >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        held_value.push_back(value);
        held_prio.push_back(prio);
        r.status = STATUS_INSERTED;
      end
    end else if (held_value.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      // Strict less-than keeps the earliest entry among equal priorities.
      best = 0;
      for (int i = 1; i < held_prio.size(); i++) begin
        if (held_prio[i] < held_prio[best]) best = i;
      end
      r.value_out = held_value[best];
      held_value.delete(best);
      held_prio.delete(best);
      r.status = STATUS_REMOVED;
    end
    r.count = 6'(held_value.size());
    return r;
  endfunction

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      if (errors_o < 10) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
      end
      errors_o = errors_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_value.delete();
      held_prio.delete();
      expected_results.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        expected_results.push_back(apply_request(op_e'(req_i.op), req_i.value,
                                                 req_i.priority_req));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_results.size() == 0) begin
          if (errors_o < 10) begin
            $display("%0t: result beat with nothing expected, value %0h status %0d count %0d",
                     $time, rsp_i.value_out, rsp_i.status, rsp_i.count);
          end
          errors_o = errors_o + 1;
        end else begin
          oldest = expected_results.pop_front();
          check_field("value_out", oldest.value_out, rsp_i.value_out);
          check_field("status", oldest.status, rsp_i.status);
          check_field("count", oldest.count, rsp_i.count);
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

>>> sim/stable_min_priority_queue_top_tb.sv
// Testbench top for the stable minimum priority queue: clock, reset, request beats
// and a randomly stalling receiver, with the checker beside the block for the verdict.
// Depends on smpq_pkg, smpq_in_if, smpq_out_if, stable_min_priority_queue_top and smpq_queue_checker.
`timescale 1ns / 100ps

module stable_min_priority_queue_top_tb;
  import smpq_pkg::*;

  localparam int CAPACITY = 32;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  bit   no_idle;
  int   hold_requests;

  smpq_in_if  req_if();
  smpq_out_if rsp_if();

  stable_min_priority_queue_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (rsp_if)
  );

  smpq_queue_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .req_i    (req_if),
    .rsp_i    (rsp_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // The receiver stalls at random unless no_idle is set and, on request, holds off for a long stretch.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        rsp_if.ready = 1'b0;
      end else if (no_idle) begin
        rsp_if.ready = 1'b1;
      end else begin
        rsp_if.ready = ($urandom_range(99) >= 32);
      end
    end
  end

  task automatic send_request(input op_e op, input value_t value, input prio_t prio);
    while (!no_idle && $urandom_range(99) < 32) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid        = 1'b1;
    req_if.op           = op;
    req_if.value        = value;
    req_if.priority_req = prio;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  function automatic prio_t pick_priority();
    prio_t p;
    case ($urandom_range(3))
      1: p = prio_t'($signed($urandom_range(6)) - 3);
      2: begin
        case ($urandom_range(3))
          0: p = 16'sh8000;
          1: p = 16'sh7fff;
          2: p = 16'sh0000;
          default: p = 16'shffff;
        endcase
      end
      default: p = prio_t'($urandom_range(65535));
    endcase
    return p;
  endfunction

  initial begin
    int insert_pct[10];
    op_e op;
    insert_pct = '{90, 60, 50, 15, 85, 50, 10, 70, 95, 30};
    no_idle             = 1'b0;
    hold_requests       = 0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_INSERT;
    req_if.value        = '0;
    req_if.priority_req = '0;
    rst_n               = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Removal from an empty queue, extreme values and priorities, and ties that must
    // come out in arrival order.
    send_request(OP_REMOVE, 16'h0000, 16'sh0000);
    send_request(OP_INSERT, 16'hffff, 16'sh7fff);
    send_request(OP_INSERT, 16'h0000, 16'sh8000);
    send_request(OP_INSERT, 16'h1234, 16'sh0000);
    send_request(OP_INSERT, 16'habcd, 16'shffff);
    send_request(OP_INSERT, 16'h5555, 16'sh8000);
    send_request(OP_INSERT, 16'haaaa, 16'sh0000);
    repeat (7) send_request(OP_REMOVE, 16'hffff, 16'shffff);
    for (int i = 1; i <= 4; i++) send_request(OP_INSERT, value_t'(i), 16'sh0007);
    repeat (4) send_request(OP_REMOVE, 16'h0000, 16'sh0000);

    // Phases mostly lean toward inserts or removes so the queue both fills up and drains.
    for (int seg = 0; seg < 10; seg++) begin
      no_idle = (seg == 6);
      if (seg == 4) hold_requests = hold_requests + 1;
      for (int n = 0; n < 50; n++) begin
        op = ($urandom_range(99) < insert_pct[seg]) ? OP_INSERT : OP_REMOVE;
        send_request(op, value_t'($urandom_range(65535)), pick_priority());
      end
    end
    no_idle      = 1'b0;
    req_if.valid = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> stable_min_priority_queue_top.f
src/smpq_pkg.sv
src/smpq_in_if.sv
src/smpq_out_if.sv
src/smpq_ram.sv
src/smpq_ctrl.sv
src/smpq_datapath.sv
src/stable_min_priority_queue_top.sv
sim/smpq_queue_checker.sv
sim/stable_min_priority_queue_top_tb.sv
